// ===== rtl/core/mmsc_pkg.sv =====
package mmsc_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned DiffW  = RawW + 1;
  localparam int unsigned OffW   = DiffW + 1;
  localparam int unsigned FieldW = OffW + 1;
  localparam int unsigned NumAxes = 3;

  localparam logic signed [DiffW-1:0] MinReset = DiffW'(65535);
  localparam logic signed [DiffW-1:0] MaxReset = DiffW'(-65536);

  localparam logic [RawW-1:0] ZeroCodeReset    = 16'd32768;
  localparam logic [RawW-1:0] EnterLimitReset  = 16'd10240;
  localparam logic [RawW-1:0] ExitLimitReset   = 16'd8192;
  localparam logic [RawW-1:0] CheckPeriodReset = 16'd250;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_CAL    = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ACT_NONE         = 2'd0,
    ACT_ENTER_SINGLE = 2'd1,
    ACT_ENTER_CONT   = 2'd2,
    ACT_SELF_TEST    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_ZERO_CODE    = 2'd0,
    CFG_ENTER_LIMIT  = 2'd1,
    CFG_EXIT_LIMIT   = 2'd2,
    CFG_CHECK_PERIOD = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    MODE_CONT   = 1'b0,
    MODE_SINGLE = 1'b1
  } mode_e;

  typedef struct packed {
    logic signed [FieldW-1:0] x_field;
    logic signed [FieldW-1:0] y_field;
    logic signed [FieldW-1:0] z_field;
    logic                     single_mode;
    action_e                  action;
  } result_t;

endpackage

// ===== rtl/core/mmsc_lane.sv =====
module mmsc_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  mmsc_pkg::req_e                     req_i,
  input  logic [mmsc_pkg::RawW-1:0]          raw_i,
  input  logic [mmsc_pkg::RawW-1:0]          zero_code_i,
  input  logic                               any_collected_i,
  output logic signed [mmsc_pkg::FieldW-1:0] field_o,
  output logic [mmsc_pkg::RawW-1:0]          mag_o
);
  import mmsc_pkg::*;

  logic signed [DiffW-1:0]  diff;
  logic signed [DiffW-1:0]  neg_diff;
  logic signed [OffW-1:0]   twice;
  logic signed [FieldW-1:0] corrected;
  logic signed [OffW-1:0]   off_q, off_d;
  logic signed [DiffW-1:0]  min_q, min_d, max_q, max_d;
  logic                     is_sample;

  assign is_sample = (req_i == REQ_SAMPLE) || (req_i == REQ_CAL);

  assign diff      = $signed({1'b0, raw_i}) - $signed({1'b0, zero_code_i});
  assign neg_diff  = -diff;
  assign mag_o     = diff[DiffW-1] ? neg_diff[RawW-1:0] : diff[RawW-1:0];
  assign twice     = {diff, 1'b0};
  assign corrected = {twice[OffW-1], twice} - {off_q[OffW-1], off_q};
  assign field_o   = is_sample ? corrected : '0;

  always_comb begin
    off_d = off_q;
    min_d = min_q;
    max_d = max_q;
    if (accept_i) begin
      case (req_i)
        REQ_CAL: begin
          if (diff < min_q) min_d = diff;
          if (diff > max_q) max_d = diff;
        end
        REQ_FINISH: begin
          off_d = any_collected_i ? ({min_q[DiffW-1], min_q} + {max_q[DiffW-1], max_q}) : '0;
          min_d = MinReset;
          max_d = MaxReset;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      min_q <= MinReset;
      max_q <= MaxReset;
    end else begin
      off_q <= off_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

endmodule

// ===== rtl/core/mmsc_ctrl.sv =====
module mmsc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  mmsc_pkg::req_e            req_i,
  input  logic [mmsc_pkg::RawW-1:0] mag_x_i,
  input  logic [mmsc_pkg::RawW-1:0] mag_y_i,
  input  logic [mmsc_pkg::RawW-1:0] enter_limit_i,
  input  logic [mmsc_pkg::RawW-1:0] exit_limit_i,
  input  logic [mmsc_pkg::RawW-1:0] check_period_i,
  output logic                      any_collected_o,
  output logic                      single_mode_o,
  output mmsc_pkg::action_e         action_o
);
  import mmsc_pkg::*;

  mode_e             mode_q, mode_d;
  logic [RawW-1:0]   cnt_q, cnt_d;
  logic              any_q, any_d;
  logic              is_sample;

  assign is_sample = (req_i == REQ_SAMPLE) || (req_i == REQ_CAL);

  // next mode and action are shown for the word at the input; state moves on accept
  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    action_o = ACT_NONE;
    if (is_sample) begin
      case (mode_q)
        MODE_CONT: begin
          if (mag_x_i > enter_limit_i || mag_y_i > enter_limit_i) begin
            mode_d   = MODE_SINGLE;
            action_o = ACT_ENTER_SINGLE;
          end
        end
        MODE_SINGLE: begin
          if (mag_x_i < exit_limit_i && mag_y_i < exit_limit_i) begin
            mode_d   = MODE_CONT;
            action_o = ACT_ENTER_CONT;
          end else if (cnt_q >= check_period_i) begin
            cnt_d    = '0;
            action_o = ACT_SELF_TEST;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    case (req_i)
      REQ_CAL:    any_d = 1'b1;
      REQ_FINISH: any_d = 1'b0;
      default:    any_d = any_q;
    endcase
  end

  assign single_mode_o   = (mode_d == MODE_SINGLE);
  assign any_collected_o = any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CONT;
      cnt_q  <= '0;
      any_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      any_q  <= any_d;
    end
  end

`ifndef SYNTHESIS
  a_enter_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && action_o == ACT_ENTER_SINGLE |=> mode_q == MODE_SINGLE)
    else $error("enter single did not switch mode");
  a_enter_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && action_o == ACT_ENTER_CONT |=> mode_q == MODE_CONT)
    else $error("enter continuous did not switch mode");
  a_self_test_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && action_o == ACT_SELF_TEST |=> cnt_q == '0)
    else $error("self-test did not clear sample counter");
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(mode_q) && $stable(cnt_q))
    else $error("mode state moved without an accepted word");
`endif

endmodule

// ===== rtl/core/mmsc_outbuf.sv =====
module mmsc_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mmsc_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_i,
  output mmsc_pkg::result_t data_o
);
  import mmsc_pkg::*;

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_q != rd_q))
    else $error("output buffer pointers disagree with count");
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !pop_i |=> valid_o && $stable(rd_q))
    else $error("stalled word left the buffer");
`endif

endmodule

// ===== rtl/core/magnetometer_mode_switch_and_calibration.sv =====
// Magnetometer front end: takes one word per cycle (x/y/z raw codes plus a request
// type) while the output buffer has room and returns one result word per input
// word, in order. Three axis lanes subtract the zero code and the hard-iron offset
// and track calibration min/max; a shared controller runs the continuous/single
// mode hysteresis and self-test counter. Results are registered into a two-word
// output buffer; input flows at one word per cycle while results are taken, and
// while a result is stalled at most one more word is accepted. Configuration
// writes are taken any cycle and should be issued only while the block is idle.
module magnetometer_mode_switch_and_calibration (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [mmsc_pkg::RawW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic [mmsc_pkg::RawW-1:0]         x_raw_i,
  input  logic [mmsc_pkg::RawW-1:0]         y_raw_i,
  input  logic [mmsc_pkg::RawW-1:0]         z_raw_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mmsc_pkg::FieldW-1:0] x_field_o,
  output logic signed [mmsc_pkg::FieldW-1:0] y_field_o,
  output logic signed [mmsc_pkg::FieldW-1:0] z_field_o,
  output logic                              single_mode_o,
  output logic [1:0]                        action_o
);
  import mmsc_pkg::*;

  logic [RawW-1:0]          zero_q, enter_q, exit_q, period_q;
  logic                     accept;
  req_e                     req;
  logic [RawW-1:0]          raw   [NumAxes];
  logic signed [FieldW-1:0] field [NumAxes];
  logic [RawW-1:0]          mag   [NumAxes];
  logic                     any_collected;
  logic                     single_mode;
  action_e                  action;
  result_t                  res_in, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q   <= ZeroCodeReset;
      enter_q  <= EnterLimitReset;
      exit_q   <= ExitLimitReset;
      period_q <= CheckPeriodReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ZERO_CODE:    zero_q   <= cfg_data_i;
        CFG_ENTER_LIMIT:  enter_q  <= cfg_data_i;
        CFG_EXIT_LIMIT:   exit_q   <= cfg_data_i;
        CFG_CHECK_PERIOD: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;
  assign req    = req_e'(req_type_i);
  assign raw[0] = x_raw_i;
  assign raw[1] = y_raw_i;
  assign raw[2] = z_raw_i;

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    mmsc_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .accept_i        (accept),
      .req_i           (req),
      .raw_i           (raw[a]),
      .zero_code_i     (zero_q),
      .any_collected_i (any_collected),
      .field_o         (field[a]),
      .mag_o           (mag[a])
    );
  end

  mmsc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .req_i           (req),
    .mag_x_i         (mag[0]),
    .mag_y_i         (mag[1]),
    .enter_limit_i   (enter_q),
    .exit_limit_i    (exit_q),
    .check_period_i  (period_q),
    .any_collected_o (any_collected),
    .single_mode_o   (single_mode),
    .action_o        (action)
  );

  // z magnitude plays no part in mode control
  always_comb begin
    res_in             = '0;
    res_in.x_field     = field[0];
    res_in.y_field     = field[1];
    res_in.z_field     = (mag[2] == mag[2]) ? field[2] : field[2];
    res_in.single_mode = single_mode;
    res_in.action      = action;
  end

  mmsc_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (res_in),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .pop_i   (out_ready_i),
    .data_o  (res_out)
  );

  assign x_field_o     = res_out.x_field;
  assign y_field_o     = res_out.y_field;
  assign z_field_o     = res_out.z_field;
  assign single_mode_o = res_out.single_mode;
  assign action_o      = res_out.action;

endmodule

// ===== tb/sv/magnetometer_result_checker.sv =====
module magnetometer_result_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [mmsc_pkg::RawW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [1:0]                         req_type_i,
  input  logic [mmsc_pkg::RawW-1:0]          x_raw_i,
  input  logic [mmsc_pkg::RawW-1:0]          y_raw_i,
  input  logic [mmsc_pkg::RawW-1:0]          z_raw_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [mmsc_pkg::FieldW-1:0] x_field_i,
  input  logic signed [mmsc_pkg::FieldW-1:0] y_field_i,
  input  logic signed [mmsc_pkg::FieldW-1:0] z_field_i,
  input  logic                               single_mode_i,
  input  logic [1:0]                         action_i,
  output int unsigned                        mismatch_count_o,
  output int unsigned                        pending_o,
  output int unsigned                        checked_o,
  output int unsigned                        mode_change_count_o,
  output int unsigned                        self_test_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mmsc_pkg::*;

  logic [RawW-1:0] zero_code_q;
  logic [RawW-1:0] enter_limit_q;
  logic [RawW-1:0] exit_limit_q;
  logic [RawW-1:0] check_period_q;

  mode_e                   mode_q;
  logic [RawW-1:0]         tick_count_q;
  logic signed [OffW-1:0]  hard_iron_q [NumAxes];
  logic signed [DiffW-1:0] lowest_q    [NumAxes];
  logic signed [DiffW-1:0] highest_q   [NumAxes];
  logic                    collected_q;

  result_t expected_fields [$];
  result_t oldest;

  // Advances the mode controller and calibration state by one word and
  // returns the result word the block should give for it.
  function automatic result_t predict_result(input logic [1:0] req,
                                             input logic [RawW-1:0] x,
                                             input logic [RawW-1:0] y,
                                             input logic [RawW-1:0] z);
    result_t res;
    int      d [NumAxes];
    int      mag_x;
    int      mag_y;
    int      sum;
    res = '0;
    case (req)
      REQ_FINISH: begin
        for (int i = 0; i < NumAxes; i++) begin
          sum = int'(lowest_q[i]) + int'(highest_q[i]);
          hard_iron_q[i] = collected_q ? OffW'(sum) : OffW'(0);
          lowest_q[i]    = MinReset;
          highest_q[i]   = MaxReset;
        end
        collected_q = 1'b0;
      end
      REQ_SAMPLE, REQ_CAL: begin
        d[0] = int'(x) - int'(zero_code_q);
        d[1] = int'(y) - int'(zero_code_q);
        d[2] = int'(z) - int'(zero_code_q);
        res.x_field = FieldW'(2 * d[0] - int'(hard_iron_q[0]));
        res.y_field = FieldW'(2 * d[1] - int'(hard_iron_q[1]));
        res.z_field = FieldW'(2 * d[2] - int'(hard_iron_q[2]));
        mag_x = (d[0] < 0) ? -d[0] : d[0];
        mag_y = (d[1] < 0) ? -d[1] : d[1];
        if (mode_q == MODE_CONT) begin
          if (mag_x > int'(enter_limit_q) || mag_y > int'(enter_limit_q)) begin
            mode_q     = MODE_SINGLE;
            res.action = ACT_ENTER_SINGLE;
          end
        end else if (mag_x < int'(exit_limit_q) && mag_y < int'(exit_limit_q)) begin
          mode_q     = MODE_CONT;
          res.action = ACT_ENTER_CONT;
        end else if (tick_count_q >= check_period_q) begin
          tick_count_q = '0;
          res.action   = ACT_SELF_TEST;
        end else begin
          tick_count_q = tick_count_q + 1'b1;
        end
        // min/max track the raw offset from zero code, not the corrected value
        if (req == REQ_CAL) begin
          for (int i = 0; i < NumAxes; i++) begin
            if (d[i] < int'(lowest_q[i]))  lowest_q[i]  = DiffW'(d[i]);
            if (d[i] > int'(highest_q[i])) highest_q[i] = DiffW'(d[i]);
          end
          collected_q = 1'b1;
        end
      end
      default: ;
    endcase
    res.single_mode = mode_q;
    return res;
  endfunction

  task automatic report(input string what, input logic signed [31:0] want,
                        input logic signed [31:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_code_q    = ZeroCodeReset;
      enter_limit_q  = EnterLimitReset;
      exit_limit_q   = ExitLimitReset;
      check_period_q = CheckPeriodReset;
      mode_q         = MODE_CONT;
      tick_count_q   = '0;
      collected_q    = 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        hard_iron_q[i] = '0;
        lowest_q[i]    = MinReset;
        highest_q[i]   = MaxReset;
      end
      expected_fields.delete();
      mismatch_count_o    = 0;
      pending_o           = 0;
      checked_o           = 0;
      mode_change_count_o = 0;
      self_test_count_o   = 0;
    end else begin
      // a result word always leaves after its input word is accepted, never with it
      if (out_valid_i && out_ready_i) begin
        if (expected_fields.size() == 0) begin
          report("unexpected result word, x_field", 'x, x_field_i);
        end else begin
          oldest = expected_fields.pop_front();
          checked_o++;
          if (x_field_i !== oldest.x_field) report("x_field", oldest.x_field, x_field_i);
          if (y_field_i !== oldest.y_field) report("y_field", oldest.y_field, y_field_i);
          if (z_field_i !== oldest.z_field) report("z_field", oldest.z_field, z_field_i);
          if (single_mode_i !== oldest.single_mode) begin
            report("single_mode", oldest.single_mode, single_mode_i);
          end
          if (action_i !== oldest.action) report("action", oldest.action, action_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ZERO_CODE:    zero_code_q    = cfg_data_i;
          CFG_ENTER_LIMIT:  enter_limit_q  = cfg_data_i;
          CFG_EXIT_LIMIT:   exit_limit_q   = cfg_data_i;
          CFG_CHECK_PERIOD: check_period_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        oldest = predict_result(req_type_i, x_raw_i, y_raw_i, z_raw_i);
        if (oldest.action == ACT_ENTER_SINGLE || oldest.action == ACT_ENTER_CONT) begin
          mode_change_count_o++;
        end
        if (oldest.action == ACT_SELF_TEST) self_test_count_o++;
        expected_fields.push_back(oldest);
      end
      pending_o = expected_fields.size();
    end
  end

endmodule

// ===== tb/sv/magnetometer_mode_switch_and_calibration_test.sv =====
module magnetometer_mode_switch_and_calibration_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mmsc_pkg::*;

  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned NumPhases      = 10;
  localparam int unsigned RandomPerPhase = 95;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [1:0]               cfg_index_i = CFG_ZERO_CODE;
  logic [RawW-1:0]          cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               req_type_i  = REQ_SAMPLE;
  logic [RawW-1:0]          x_raw_i     = '0;
  logic [RawW-1:0]          y_raw_i     = '0;
  logic [RawW-1:0]          z_raw_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [FieldW-1:0] x_field_o;
  logic signed [FieldW-1:0] y_field_o;
  logic signed [FieldW-1:0] z_field_o;
  logic                     single_mode_o;
  logic [1:0]               action_o;

  int unsigned mismatches;
  int unsigned pending_words;
  int unsigned checked_words;
  int unsigned mode_changes;
  int unsigned self_tests;

  // register values as last written, used only to aim the random samples
  logic [RawW-1:0] cur_zero  = ZeroCodeReset;
  logic [RawW-1:0] cur_enter = EnterLimitReset;
  logic [RawW-1:0] cur_exit  = ExitLimitReset;
  int unsigned     settings_applied = 0;

  int unsigned     burst_left  = 0;
  int unsigned     idle_cycles = 0;
  logic [15:0]     ready_pattern = '1;
  int unsigned     pattern_pos = 0;

  magnetometer_mode_switch_and_calibration u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .x_raw_i       (x_raw_i),
    .y_raw_i       (y_raw_i),
    .z_raw_i       (z_raw_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .x_field_o     (x_field_o),
    .y_field_o     (y_field_o),
    .z_field_o     (z_field_o),
    .single_mode_o (single_mode_o),
    .action_o      (action_o)
  );

  magnetometer_result_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .req_type_i          (req_type_i),
    .x_raw_i             (x_raw_i),
    .y_raw_i             (y_raw_i),
    .z_raw_i             (z_raw_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .x_field_i           (x_field_o),
    .y_field_i           (y_field_o),
    .z_field_i           (z_field_o),
    .single_mode_i       (single_mode_o),
    .action_i            (action_o),
    .mismatch_count_o    (mismatches),
    .pending_o           (pending_words),
    .checked_o           (checked_words),
    .mode_change_count_o (mode_changes),
    .self_test_count_o   (self_tests)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver back-pressure: a 16-bit ready pattern, played three times over before it is redrawn.
  // Bit 0 is always set so the output never stalls for good.
  always @(negedge clk_i) begin
    if (pattern_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = '1;
        1:       ready_pattern = 16'h0001;
        2:       ready_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
        default: ready_pattern = 16'($urandom) | 16'h0001;
      endcase
    end
    out_ready_i = ready_pattern[pattern_pos % 16];
    pattern_pos = (pattern_pos + 1) % 48;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending_words);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sender: words go out in bursts; a new burst may start after a gap.
  task automatic send_word(input logic [1:0] req, input logic [RawW-1:0] x,
                           input logic [RawW-1:0] y, input logic [RawW-1:0] z);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    req_type_i = req;
    x_raw_i    = x;
    y_raw_i    = y;
    z_raw_i    = z;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_words != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [RawW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic apply_setting(input logic [RawW-1:0] zero, input logic [RawW-1:0] enter,
                               input logic [RawW-1:0] leave, input logic [RawW-1:0] period);
    write_reg(CFG_ZERO_CODE, zero);
    write_reg(CFG_ENTER_LIMIT, enter);
    write_reg(CFG_EXIT_LIMIT, leave);
    write_reg(CFG_CHECK_PERIOD, period);
    cur_zero  = zero;
    cur_enter = enter;
    cur_exit  = leave;
    settings_applied++;
  endtask

  // Axis codes aimed at the mode thresholds around the current zero code,
  // with a share of fully random codes.
  function automatic logic [RawW-1:0] pick_raw();
    int mag;
    int val;
    case ($urandom_range(0, 5))
      0:       mag = $urandom_range(0, cur_exit);
      1:       mag = int'(cur_enter) - 1 + int'($urandom_range(0, 2));
      2:       mag = int'(cur_exit) - 1 + int'($urandom_range(0, 2));
      3:       mag = $urandom_range(cur_enter, 65535);
      default: return RawW'($urandom);
    endcase
    if (mag < 0) mag = 0;
    val = ($urandom_range(0, 1) == 0) ? int'(cur_zero) + mag : int'(cur_zero) - mag;
    if (val < 0) val = 0;
    else if (val > 65535) val = 65535;
    return RawW'(val);
  endfunction

  function automatic logic [1:0] pick_req();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return REQ_SAMPLE;
    if (r < 82) return REQ_CAL;
    if (r < 95) return REQ_FINISH;
    return REQ_NONE;
  endfunction

  initial begin
    logic [RawW-1:0] enter;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words at reset settings: zero 32768, enter 10240, exit 8192
    send_word(REQ_SAMPLE, 16'd32768, 16'd32768, 16'd32768);
    send_word(REQ_SAMPLE, 16'd0, 16'd65535, 16'd0);         // X far out: go single
    send_word(REQ_SAMPLE, 16'd65535, 16'd65535, 16'd65535);
    send_word(REQ_SAMPLE, 16'd40960, 16'd32768, 16'd1);     // |dx| equals exit: stay
    send_word(REQ_SAMPLE, 16'd40959, 16'd24577, 16'd2);     // just inside exit: back
    send_word(REQ_SAMPLE, 16'd43008, 16'd32768, 16'd3);     // |dx| equals enter: stay
    send_word(REQ_SAMPLE, 16'd32768, 16'd22527, 16'd4);     // Y just past enter
    send_word(REQ_SAMPLE, 16'd32768, 16'd32768, 16'd32768);
    send_word(REQ_CAL, 16'd0, 16'd65535, 16'd0);
    send_word(REQ_CAL, 16'd65535, 16'd0, 16'd65535);
    send_word(REQ_CAL, 16'd32868, 16'd32468, 16'd32773);
    send_word(REQ_FINISH, 16'hffff, 16'h0000, 16'hffff);
    send_word(REQ_SAMPLE, 16'd32768, 16'd32768, 16'd32768);
    send_word(REQ_SAMPLE, 16'd0, 16'd0, 16'd0);
    send_word(REQ_NONE, 16'hffff, 16'hffff, 16'hffff);      // REQ_NONE: no sample, no calibration
    send_word(REQ_FINISH, 16'd0, 16'd0, 16'd0);             // finish with nothing collected
    send_word(REQ_SAMPLE, 16'd12345, 16'd54321, 16'd32768);
    drain();

    // zero check period: every sample or calibration word that stays in single mode gives a self-test
    write_reg(CFG_CHECK_PERIOD, 16'd0);
    send_word(REQ_SAMPLE, 16'd0, 16'd0, 16'd0);
    send_word(REQ_CAL, 16'd0, 16'd65535, 16'd0);
    send_word(REQ_SAMPLE, 16'd65535, 16'd65535, 16'd65535);
    send_word(REQ_NONE, 16'd0, 16'd0, 16'd0);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: apply_setting(ZeroCodeReset, EnterLimitReset, ExitLimitReset, CheckPeriodReset);
        1: apply_setting(16'd32768, 16'd1000, 16'd800, 16'd3);
        2: apply_setting(16'd0, 16'hffff, 16'd0, 16'hffff);
        3: apply_setting(16'hffff, 16'd0, 16'hffff, 16'd0);
        4: apply_setting(16'd32768, 16'h0fff, 16'h0400, 16'd0);
        NumPhases - 1: apply_setting(RawW'($urandom), RawW'($urandom), RawW'($urandom),
                                     RawW'($urandom));
        default: begin
          enter = RawW'($urandom_range(0, 20000));
          apply_setting(RawW'($urandom), enter, RawW'($urandom_range(0, enter)),
                        RawW'($urandom_range(0, 6)));
        end
      endcase
      repeat (RandomPerPhase) send_word(pick_req(), pick_raw(), pick_raw(), pick_raw());
      drain();
    end

    repeat (8) @(negedge clk_i);
    $display("Checked %0d result words under %0d register settings plus reset values",
             checked_words, settings_applied);
    $display("Mode changes seen: %0d, self-test requests seen: %0d", mode_changes, self_tests);
    if (mismatches == 0 && pending_words == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
